// ----- design/lc2k_pkg.sv -----
`default_nettype none

package lc2k_pkg;

  localparam int unsigned MEM_WORDS_DEF = 65536;
  localparam int unsigned REG_COUNT     = 8;
  localparam int unsigned REG_AW        = 3;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned FIELD_AW      = 16;
  localparam int unsigned OFFSET_W      = 16;
  localparam int unsigned OP_W          = 3;

  localparam int unsigned OP_LSB = 22;
  localparam int unsigned RA_LSB = 19;
  localparam int unsigned RB_LSB = 16;
  localparam int unsigned RD_LSB = 0;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } lc2k_op_e;

  typedef struct packed {
    logic clear_we;
    logic accept;
    logic fetch;
    logic decode;
    logic wrap_start;
    logic commit;
    logic load_wb;
    logic out_load;
  } lc2k_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic halted;
    logic wrap_done;
    logic needs_wrap;
    logic is_lw;
    logic out_free;
  } lc2k_sts_t;

endpackage

`default_nettype wire

// ----- design/lc2k_if.sv -----
`default_nettype none

interface lc2k_req_if import lc2k_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [FIELD_AW-1:0]        load_addr;
  logic signed [WORD_W-1:0]   load_word;

  modport source (output valid, req_type, load_addr, load_word, input ready);
  modport sink   (input valid, req_type, load_addr, load_word, output ready);
endinterface

interface lc2k_rsp_if import lc2k_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FIELD_AW-1:0]        next_pc;
  logic                       halted;
  logic [WORD_W-1:0]          executed_count;
  logic [OP_W-1:0]            exec_opcode;
  logic                       executed;
  logic                       reg_written;
  logic [REG_AW-1:0]          reg_index;
  logic signed [WORD_W-1:0]   reg_value;
  logic                       mem_written;
  logic [FIELD_AW-1:0]        store_addr;
  logic signed [WORD_W-1:0]   store_value;

  modport source (
    output valid, next_pc, halted, executed_count, exec_opcode, executed, reg_written,
           reg_index, reg_value, mem_written, store_addr, store_value,
    input  ready
  );
  modport sink (
    input  valid, next_pc, halted, executed_count, exec_opcode, executed, reg_written,
           reg_index, reg_value, mem_written, store_addr, store_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/lc2k_ram.sv -----
`default_nettype none

module lc2k_ram import lc2k_pkg::*; #(
  parameter int unsigned WIDTH = WORD_W,
  parameter int unsigned DEPTH = MEM_WORDS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/lc2k_wrap.sv -----
`default_nettype none

module lc2k_wrap import lc2k_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  localparam int unsigned AW       = $clog2(MEM_WORDS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] value_i,
  output logic                   done_o,
  output logic      [AW-1:0]     result_o
);

  localparam bit POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

  if (POW2) begin : g_mask
    logic          done_q;
    logic [AW-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= value_i[AW-1:0];
      end
    end

    assign done_o   = done_q;
    assign result_o = rem_q;
  end else begin : g_recip
    // reciprocal multiply gives the quotient or one less, one subtract fixes it
    localparam int unsigned     RW      = WORD_W - 7;
    localparam logic [63:0]     RECIP64 = (64'd1 << WORD_W) / 64'(MEM_WORDS);
    localparam logic [RW-1:0]   RECIP   = RW'(RECIP64);
    localparam logic [AW:0]     MODV    = (AW+1)'(MEM_WORDS);

    logic                 s1_q;
    logic                 s2_q;
    logic                 done_q;
    logic [WORD_W-1:0]    val_q;
    logic [RW-1:0]        quo_q;
    logic [AW:0]          rem_q;
    logic [WORD_W+RW-1:0] prod;
    logic [RW-1:0]        qm;
    logic [AW:0]          rem_d;

    assign prod  = (WORD_W+RW)'(val_q) * (WORD_W+RW)'(RECIP);
    assign qm    = quo_q * RW'(MEM_WORDS);
    // below twice the modulus, so the low bits are enough
    assign rem_d = val_q[AW:0] - qm[AW:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        s1_q   <= start_i;
        s2_q   <= s1_q;
        done_q <= s2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        val_q <= value_i;
      end
      if (s1_q) begin
        quo_q <= prod[WORD_W +: RW];
      end
      if (s2_q) begin
        rem_q <= rem_d;
      end
    end

    assign done_o   = done_q;
    assign result_o = (rem_q >= MODV) ? AW'(rem_q - MODV) : rem_q[AW-1:0];
  end

endmodule

`default_nettype wire

// ----- design/lc2k_ctrl.sv -----
`default_nettype none

module lc2k_ctrl import lc2k_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  input  wire logic      req_type_i,
  output logic           req_ready_o,
  input  wire lc2k_sts_t sts_i,
  output lc2k_cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LDW    = 9'b000000100,
    S_FETCH  = 9'b000001000,
    S_DECODE = 9'b000010000,
    S_EXEC   = 9'b000100000,
    S_WRAP   = 9'b001000000,
    S_LOAD   = 9'b010000000,
    S_DONE   = 9'b100000000
  } lc2k_state_e;

  lc2k_state_e state_q;
  lc2k_state_e state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          if (req_type_i == REQ_LOAD) begin
            state_d = S_LDW;
          end else if (sts_i.halted) begin
            state_d = S_DONE;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_LDW: begin
        cmd_o.wrap_start = 1'b1;
        state_d          = S_WRAP;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.needs_wrap) begin
          cmd_o.wrap_start = 1'b1;
          state_d          = S_WRAP;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_WRAP: begin
        if (sts_i.wrap_done) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.is_lw ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: begin
        cmd_o.load_wb = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/lc2k_dp.sv -----
`default_nettype none

module lc2k_dp import lc2k_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lc2k_cmd_t                cmd_i,
  output lc2k_sts_t                     sts_o,
  input  wire logic                     req_type_i,
  input  wire logic [FIELD_AW-1:0]      load_addr_i,
  input  wire logic signed [WORD_W-1:0] load_word_i,
  input  wire logic                     rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic [FIELD_AW-1:0]           next_pc_o,
  output logic                          halted_o,
  output logic [WORD_W-1:0]             executed_count_o,
  output logic [OP_W-1:0]               exec_opcode_o,
  output logic                          executed_o,
  output logic                          reg_written_o,
  output logic [REG_AW-1:0]             reg_index_o,
  output logic signed [WORD_W-1:0]      reg_value_o,
  output logic                          mem_written_o,
  output logic [FIELD_AW-1:0]           store_addr_o,
  output logic signed [WORD_W-1:0]      store_value_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // request and instruction
  logic                 req_type_q;
  logic [FIELD_AW-1:0]  load_addr_q;
  logic [WORD_W-1:0]    load_word_q;
  logic [WORD_W-1:0]    ir_q;

  // architectural state
  logic [AW-1:0]        pc_q;
  logic                 halt_q;
  logic [WORD_W-1:0]    cnt_q;
  logic [REG_COUNT-1:0] valid_q;
  logic                 av_q;
  logic                 bv_q;
  logic [AW-1:0]        clr_q;

  // per-request staging
  logic [OP_W-1:0]      st_opc_q;
  logic                 st_ex_q;
  logic                 st_rw_q;
  logic [REG_AW-1:0]    st_ri_q;
  logic [WORD_W-1:0]    st_rv_q;
  logic                 st_mw_q;
  logic [AW-1:0]        st_sa_q;
  logic [WORD_W-1:0]    st_sv_q;

  // response register
  logic                 out_valid_q;
  logic [FIELD_AW-1:0]  o_pc_q;
  logic                 o_halt_q;
  logic [WORD_W-1:0]    o_cnt_q;
  logic [OP_W-1:0]      o_opc_q;
  logic                 o_ex_q;
  logic                 o_rw_q;
  logic [REG_AW-1:0]    o_ri_q;
  logic [WORD_W-1:0]    o_rv_q;
  logic                 o_mw_q;
  logic [FIELD_AW-1:0]  o_sa_q;
  logic [WORD_W-1:0]    o_sv_q;

  lc2k_op_e             op;
  logic [REG_AW-1:0]    ra;
  logic [REG_AW-1:0]    rb;
  logic [REG_AW-1:0]    rd;
  logic [WORD_W-1:0]    off;
  logic [WORD_W-1:0]    a;
  logic [WORD_W-1:0]    b;
  logic                 eq;
  logic [AW-1:0]        pc_inc;
  logic [AW-1:0]        pc_next;
  logic                 is_step;
  logic                 commit_step;
  logic [WORD_W-1:0]    wrap_in;
  logic                 wrap_done;
  logic [AW-1:0]        wa;
  logic [WORD_W-1:0]    alu;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;

  logic                 rf_we;
  logic [REG_AW-1:0]    rf_waddr;
  logic [WORD_W-1:0]    rf_wdata;
  logic [REG_AW-1:0]    rf_ra;
  logic [REG_AW-1:0]    rf_rb;
  logic [WORD_W-1:0]    rfa_rdata;
  logic [WORD_W-1:0]    rfb_rdata;

  assign op  = lc2k_op_e'(ir_q[OP_LSB +: OP_W]);
  assign ra  = ir_q[RA_LSB +: REG_AW];
  assign rb  = ir_q[RB_LSB +: REG_AW];
  assign rd  = ir_q[RD_LSB +: REG_AW];
  assign off = {{(WORD_W - OFFSET_W){ir_q[OFFSET_W-1]}}, ir_q[OFFSET_W-1:0]};

  // registers never written read as zero
  assign a  = av_q ? rfa_rdata : '0;
  assign b  = bv_q ? rfb_rdata : '0;
  assign eq = (a == b);

  assign pc_inc      = (pc_q == AW'(MEM_WORDS - 1)) ? '0 : pc_q + 1'b1;
  assign is_step     = (req_type_q == REQ_STEP);
  assign commit_step = cmd_i.commit && is_step;

  always_comb begin
    case (op)
      OP_LW, OP_SW: wrap_in = a + off;
      OP_BEQ:       wrap_in = WORD_W'(pc_q) + WORD_W'(1) + off;
      default:      wrap_in = a;
    endcase
    if (req_type_q == REQ_LOAD) begin
      wrap_in = WORD_W'(load_addr_q);
    end
  end

  lc2k_wrap #(
    .MEM_WORDS (MEM_WORDS)
  ) u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.wrap_start),
    .value_i  (wrap_in),
    .done_o   (wrap_done),
    .result_o (wa)
  );

  always_comb begin
    case (op)
      OP_ADD:  alu = a + b;
      OP_NOR:  alu = ~(a | b);
      default: alu = WORD_W'(pc_inc);
    endcase
  end

  always_comb begin
    case (op)
      OP_BEQ:  pc_next = eq ? wa : pc_inc;
      OP_JALR: pc_next = (ra == rb) ? pc_inc : wa;
      default: pc_next = pc_inc;
    endcase
  end

  // word memory: clear sweep, load request, store
  assign mem_we    = cmd_i.clear_we
                  || (cmd_i.commit && (!is_step || (op == OP_SW)));
  assign mem_waddr = cmd_i.clear_we ? clr_q : wa;
  assign mem_wdata = cmd_i.clear_we ? '0 : (is_step ? b : load_word_q);
  assign mem_re    = cmd_i.fetch || (commit_step && (op == OP_LW));
  assign mem_raddr = cmd_i.fetch ? pc_q : wa;

  lc2k_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // register file: two copies for two read ports
  assign rf_ra    = mem_rdata[RA_LSB +: REG_AW];
  assign rf_rb    = mem_rdata[RB_LSB +: REG_AW];
  assign rf_we    = (commit_step && (op inside {OP_ADD, OP_NOR, OP_JALR})) || cmd_i.load_wb;
  assign rf_waddr = (cmd_i.load_wb || (op == OP_JALR)) ? rb : rd;
  assign rf_wdata = cmd_i.load_wb ? mem_rdata : alu;

  lc2k_ram #(
    .WIDTH (WORD_W),
    .DEPTH (REG_COUNT)
  ) u_rfa (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (cmd_i.decode),
    .raddr_i (rf_ra),
    .rdata_o (rfa_rdata)
  );

  lc2k_ram #(
    .WIDTH (WORD_W),
    .DEPTH (REG_COUNT)
  ) u_rfb (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (cmd_i.decode),
    .raddr_i (rf_rb),
    .rdata_o (rfb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      halt_q      <= 1'b0;
      cnt_q       <= '0;
      valid_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_we) begin
        clr_q <= clr_q + 1'b1;
      end
      if (commit_step) begin
        pc_q  <= pc_next;
        cnt_q <= cnt_q + 1'b1;
        if (op == OP_HALT) begin
          halt_q <= 1'b1;
        end
      end
      if (rf_we) begin
        valid_q[rf_waddr] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q  <= req_type_i;
      load_addr_q <= load_addr_i;
      load_word_q <= load_word_i;
      st_opc_q    <= '0;
      st_ex_q     <= 1'b0;
      st_rw_q     <= 1'b0;
      st_ri_q     <= '0;
      st_rv_q     <= '0;
      st_mw_q     <= 1'b0;
      st_sa_q     <= '0;
      st_sv_q     <= '0;
    end
    if (cmd_i.decode) begin
      ir_q <= mem_rdata;
      av_q <= valid_q[rf_ra];
      bv_q <= valid_q[rf_rb];
    end
    if (commit_step) begin
      st_opc_q <= op;
      st_ex_q  <= 1'b1;
      st_rw_q  <= (op inside {OP_ADD, OP_NOR, OP_LW, OP_JALR});
      st_ri_q  <= (op inside {OP_ADD, OP_NOR}) ? rd
                : ((op inside {OP_LW, OP_JALR}) ? rb : '0);
      st_rv_q  <= (op inside {OP_ADD, OP_NOR, OP_JALR}) ? alu : '0;
      st_mw_q  <= (op == OP_SW);
      st_sa_q  <= (op == OP_SW) ? wa : '0;
      st_sv_q  <= (op == OP_SW) ? b : '0;
    end
    if (cmd_i.load_wb) begin
      st_rv_q <= mem_rdata;
    end
    if (cmd_i.out_load) begin
      o_pc_q   <= FIELD_AW'(pc_q);
      o_halt_q <= halt_q;
      o_cnt_q  <= cnt_q;
      o_opc_q  <= st_opc_q;
      o_ex_q   <= st_ex_q;
      o_rw_q   <= st_rw_q;
      o_ri_q   <= st_ri_q;
      o_rv_q   <= st_rv_q;
      o_mw_q   <= st_mw_q;
      o_sa_q   <= FIELD_AW'(st_sa_q);
      o_sv_q   <= st_sv_q;
    end
  end

  assign sts_o.clear_last = (clr_q == AW'(MEM_WORDS - 1));
  assign sts_o.halted     = halt_q;
  assign sts_o.wrap_done  = wrap_done;
  assign sts_o.needs_wrap = is_step
                         && ((op inside {OP_LW, OP_SW, OP_JALR}) || ((op == OP_BEQ) && eq));
  assign sts_o.is_lw      = is_step && (op == OP_LW);
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o      = out_valid_q;
  assign next_pc_o        = o_pc_q;
  assign halted_o         = o_halt_q;
  assign executed_count_o = o_cnt_q;
  assign exec_opcode_o    = o_opc_q;
  assign executed_o       = o_ex_q;
  assign reg_written_o    = o_rw_q;
  assign reg_index_o      = o_ri_q;
  assign reg_value_o      = o_rv_q;
  assign mem_written_o    = o_mw_q;
  assign store_addr_o     = o_sa_q;
  assign store_value_o    = o_sv_q;

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag dropped");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(cnt_q))
    else $error("instruction count moved without commit");

  a_halt_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halt_q) |-> $past(cmd_i.commit))
    else $error("halt set outside commit");

  a_load_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_wb |-> $past(cmd_i.commit) && $past(mem_re))
    else $error("load writeback without memory read");

  a_fetch_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fetch |-> !mem_we && !rf_we)
    else $error("state write during fetch");
`endif

endmodule

`default_nettype wire

// ----- design/lc2k_instruction_step_top.sv -----
`default_nettype none

// sequence: a load request is accepted, its address reduced, the word written, then the
//   response loaded; a step fetches, decodes and executes, reduces an address or target
//   for lw, sw, jalr and taken beq, and writes back for lw; a step after halt goes straight to the response
// a new request is taken while the previous response still waits; address reduction is
//   a mask for a power-of-two MEM_WORDS and a reciprocal multiply otherwise
// reset: pc, registers, halt flag and count clear at once; the word memory is then
//   swept to zero with req ready low
module lc2k_instruction_step_top import lc2k_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lc2k_req_if.sink    req_i,
  lc2k_rsp_if.source  rsp_o
);

  lc2k_cmd_t cmd;
  lc2k_sts_t sts;

  lc2k_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lc2k_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .load_addr_i      (req_i.load_addr),
    .load_word_i      (req_i.load_word),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .next_pc_o        (rsp_o.next_pc),
    .halted_o         (rsp_o.halted),
    .executed_count_o (rsp_o.executed_count),
    .exec_opcode_o    (rsp_o.exec_opcode),
    .executed_o       (rsp_o.executed),
    .reg_written_o    (rsp_o.reg_written),
    .reg_index_o      (rsp_o.reg_index),
    .reg_value_o      (rsp_o.reg_value),
    .mem_written_o    (rsp_o.mem_written),
    .store_addr_o     (rsp_o.store_addr),
    .store_value_o    (rsp_o.store_value)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  import lc2k_pkg::*;

  localparam int unsigned MEM_WORDS        = MEM_WORDS_DEF;
  localparam int          HOLD_CYCLES      = 400;
  localparam int          WATCHDOG_LIMIT   = 300000;
  localparam int          DRAIN_CYCLES     = 20;
  localparam int          RANDOM_ITEMS_END = 1340;

  typedef struct {
    logic [FIELD_AW-1:0] next_pc;
    logic                halted;
    logic [WORD_W-1:0]   executed_count;
    lc2k_op_e            exec_opcode;
    logic                executed;
    logic                reg_written;
    logic [REG_AW-1:0]   reg_index;
    logic [WORD_W-1:0]   reg_value;
    logic                mem_written;
    logic [FIELD_AW-1:0] store_addr;
    logic [WORD_W-1:0]   store_value;
  } lc2k_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lc2k_req_if req_bus ();
  lc2k_rsp_if rsp_bus ();

  lc2k_instruction_step_top #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // machine state as the block should hold it after every accepted request
  logic [FIELD_AW-1:0] model_pc;
  logic [WORD_W-1:0]   model_regs [REG_COUNT];
  logic [WORD_W-1:0]   model_mem [MEM_WORDS];
  logic                model_halted;
  logic [WORD_W-1:0]   model_count;

  lc2k_result_t pending_results[$];
  int           mismatch_count = 0;
  int           sent_count = 0;
  int           idle_cycles = 0;
  bit           req_idle_en = 1'b1;
  bit           rsp_idle_en = 1'b1;
  bit           hold_rsp = 1'b0;

  function automatic logic [FIELD_AW-1:0] word_index(input logic [WORD_W-1:0] addr);
    return FIELD_AW'(addr % MEM_WORDS);
  endfunction

  function automatic logic [WORD_W-1:0] widen_offset(input logic [OFFSET_W-1:0] off);
    return {{(WORD_W-OFFSET_W){off[OFFSET_W-1]}}, off};
  endfunction

  function automatic lc2k_result_t predict_request(input logic kind,
                                                   input logic [FIELD_AW-1:0] addr,
                                                   input logic [WORD_W-1:0] data);
    lc2k_result_t        res;
    logic [WORD_W-1:0]   instr;
    logic [WORD_W-1:0]   opnd_a;
    logic [WORD_W-1:0]   opnd_b;
    logic [WORD_W-1:0]   offset;
    logic [REG_AW-1:0]   ra;
    logic [REG_AW-1:0]   rb;
    logic [REG_AW-1:0]   rd;
    logic [FIELD_AW-1:0] npc;
    lc2k_op_e            op;
    res.exec_opcode = OP_ADD;
    res.executed    = 1'b0;
    res.reg_written = 1'b0;
    res.reg_index   = '0;
    res.reg_value   = '0;
    res.mem_written = 1'b0;
    res.store_addr  = '0;
    res.store_value = '0;
    if (kind == REQ_LOAD) begin
      model_mem[word_index(32'(addr))] = data;
    end else if (!model_halted) begin
      instr  = model_mem[model_pc];
      op     = lc2k_op_e'(instr[OP_LSB +: OP_W]);
      ra     = instr[RA_LSB +: REG_AW];
      rb     = instr[RB_LSB +: REG_AW];
      rd     = instr[RD_LSB +: REG_AW];
      offset = widen_offset(instr[OFFSET_W-1:0]);
      opnd_a = model_regs[ra];
      opnd_b = model_regs[rb];
      npc    = word_index(32'(model_pc) + 32'd1);
      res.exec_opcode = op;
      res.executed    = 1'b1;
      case (op)
        OP_ADD: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd;
          res.reg_value   = opnd_a + opnd_b;
        end
        OP_NOR: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd;
          res.reg_value   = ~(opnd_a | opnd_b);
        end
        OP_LW: begin
          res.reg_written = 1'b1;
          res.reg_index   = rb;
          res.reg_value   = model_mem[word_index(opnd_a + offset)];
        end
        OP_SW: begin
          res.mem_written = 1'b1;
          res.store_addr  = word_index(opnd_a + offset);
          res.store_value = opnd_b;
        end
        OP_BEQ: begin
          if (opnd_a == opnd_b) npc = word_index(32'(model_pc) + 32'd1 + offset);
        end
        OP_JALR: begin
          res.reg_written = 1'b1;
          res.reg_index   = rb;
          res.reg_value   = 32'(npc);
        end
        OP_HALT: model_halted = 1'b1;
        default: ;
      endcase
      if (res.reg_written) model_regs[res.reg_index] = res.reg_value;
      if (res.mem_written) model_mem[res.store_addr] = res.store_value;
      if (op == OP_JALR) npc = word_index(model_regs[ra]);
      model_pc    = npc;
      model_count = model_count + 32'd1;
    end
    res.next_pc        = model_pc;
    res.halted         = model_halted;
    res.executed_count = model_count;
    return res;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] encode_instr(input lc2k_op_e op,
                                                     input logic [REG_AW-1:0] ra,
                                                     input logic [REG_AW-1:0] rb,
                                                     input logic [OFFSET_W-1:0] low);
    return {7'($urandom), op, ra, rb, low};
  endfunction

  function automatic lc2k_op_e pick_op();
    lc2k_op_e ops[7] = '{OP_ADD, OP_NOR, OP_LW, OP_SW, OP_BEQ, OP_JALR, OP_NOOP};
    return ops[$urandom_range(0, 6)];
  endfunction

  // one request, then its prediction once the block has taken it
  task automatic send_req(input logic kind, input logic [FIELD_AW-1:0] addr,
                          input logic [WORD_W-1:0] data);
    int gap;
    if (req_idle_en && $urandom_range(0, 2) == 0) gap = gap_len();
    else gap = 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= kind;
    req_bus.load_addr <= addr;
    req_bus.load_word <= data;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    pending_results.push_back(predict_request(kind, addr, data));
    sent_count++;
  endtask

  task automatic load_mem(input logic [FIELD_AW-1:0] addr, input logic [WORD_W-1:0] data);
    send_req(REQ_LOAD, addr, data);
  endtask

  task automatic step_once();
    send_req(REQ_STEP, FIELD_AW'($urandom), $urandom);
  endtask

  task automatic exec_instr(input logic [WORD_W-1:0] instr);
    load_mem(model_pc, instr);
    step_once();
  endtask

  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic random_instruction();
    lc2k_op_e            op;
    logic [REG_AW-1:0]   ra;
    logic [REG_AW-1:0]   rb;
    logic [OFFSET_W-1:0] low;
    bit                  patch_next;
    int                  pick;
    pick       = $urandom_range(0, 99);
    patch_next = 1'b0;
    if (pick < 8) begin
      load_mem(FIELD_AW'($urandom), $urandom);
      return;
    end
    // run whatever word sits at the pc, unless it would stop the machine
    if (pick < 16 && model_mem[model_pc][OP_LSB +: OP_W] != OP_HALT) begin
      step_once();
      return;
    end
    op  = pick_op();
    ra  = REG_AW'($urandom);
    rb  = REG_AW'($urandom);
    low = OFFSET_W'($urandom);
    if (pick < 31) begin
      case ($urandom_range(0, 3))
        0:       low = 16'h0000;
        1:       low = 16'h7FFF;
        2:       low = 16'h8000;
        default: low = 16'hFFFF;
      endcase
    end
    case (op)
      OP_BEQ: if ($urandom_range(0, 1) == 0) rb = ra;
      OP_LW: begin
        if ($urandom_range(0, 1) == 0)
          load_mem(word_index(model_regs[ra] + widen_offset(low)), $urandom);
      end
      OP_SW: begin
        // store into the next fetch slot and run the stored word
        if ($urandom_range(0, 2) == 0 && model_regs[rb][OP_LSB +: OP_W] != OP_HALT) begin
          low        = OFFSET_W'(32'(model_pc) + 32'd1 - model_regs[ra]);
          patch_next = 1'b1;
        end
      end
      default: ;
    endcase
    exec_instr(encode_instr(op, ra, rb, low));
    if (patch_next) step_once();
  endtask

  task automatic test_directed_ops();
    step_once();
    load_mem(16'hFFFF, 32'h8000_0000);
    exec_instr(encode_instr(OP_LW, 3'd0, 3'd1, 16'hFFFF));
    exec_instr(encode_instr(OP_NOR, 3'd1, 3'd1, 16'h0002));
    exec_instr(encode_instr(OP_NOR, 3'd0, 3'd0, 16'h0003));
    exec_instr(encode_instr(OP_ADD, 3'd2, 3'd2, 16'hFFFC));
    exec_instr(encode_instr(OP_SW, 3'd3, 3'd1, 16'h7FFF));
    exec_instr(encode_instr(OP_LW, 3'd3, 3'd0, 16'h7FFF));
    exec_instr(encode_instr(OP_SW, 3'd2, 3'd2, 16'h8000));
    exec_instr(encode_instr(OP_BEQ, 3'd2, 3'd2, 16'h7FFF));
    // jump to the top word, then let the pc wrap to zero
    exec_instr(encode_instr(OP_JALR, 3'd3, 3'd6, 16'h0000));
    exec_instr({7'h7F, OP_NOOP, 3'h7, 3'h7, 16'hFFFF});
    exec_instr(encode_instr(OP_BEQ, 3'd5, 3'd5, 16'h8000));
    exec_instr(encode_instr(OP_JALR, 3'd4, 3'd4, 16'h0000));
  endtask

  task automatic test_output_backpressure();
    req_idle_en = 1'b0;
    hold_rsp    = 1'b1;
    repeat (24) random_instruction();
    req_idle_en = 1'b1;
  endtask

  task automatic test_random_programs();
    while (sent_count < RANDOM_ITEMS_END) begin
      if ($urandom_range(0, 59) == 0) req_idle_en = !req_idle_en;
      if ($urandom_range(0, 59) == 0) rsp_idle_en = !rsp_idle_en;
      random_instruction();
    end
    req_idle_en = 1'b1;
    rsp_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(2, 8)) random_instruction();
      wait_for_results();
    end
  endtask

  task automatic test_halt();
    exec_instr(encode_instr(OP_HALT, REG_AW'($urandom), REG_AW'($urandom),
                            OFFSET_W'($urandom)));
    repeat (3) step_once();
    load_mem(model_pc, encode_instr(OP_ADD, 3'd1, 3'd2, 16'h0003));
    step_once();
    repeat (3) begin
      load_mem(FIELD_AW'($urandom), $urandom);
      step_once();
    end
  endtask

  function automatic void check_field(input string name, input logic [WORD_W-1:0] expv,
                                      input logic [WORD_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    lc2k_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", 32'(want.next_pc), 32'(rsp_bus.next_pc));
        check_field("halted", 32'(want.halted), 32'(rsp_bus.halted));
        check_field("executed_count", want.executed_count, rsp_bus.executed_count);
        check_field("exec_opcode", 32'(want.exec_opcode), 32'(rsp_bus.exec_opcode));
        check_field("executed", 32'(want.executed), 32'(rsp_bus.executed));
        check_field("reg_written", 32'(want.reg_written), 32'(rsp_bus.reg_written));
        check_field("reg_index", 32'(want.reg_index), 32'(rsp_bus.reg_index));
        check_field("reg_value", want.reg_value, rsp_bus.reg_value);
        check_field("mem_written", 32'(want.mem_written), 32'(rsp_bus.mem_written));
        check_field("store_addr", 32'(want.store_addr), 32'(rsp_bus.store_addr));
        check_field("store_value", want.store_value, rsp_bus.store_value);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // response side: random stalls plus one long hold counted here
  initial begin
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= REQ_LOAD;
    req_bus.load_addr <= '0;
    req_bus.load_word <= '0;
    model_pc     = '0;
    model_halted = 1'b0;
    model_count  = '0;
    foreach (model_regs[i]) model_regs[i] = '0;
    foreach (model_mem[i]) model_mem[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_output_backpressure();
    test_random_programs();
    test_drain_pause();
    test_halt();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
